// ===== design/ufljs_pkg.sv =====
// ---------------------------------------------------------------------------
// ufljs_pkg
// Shared types and constants for the flow loss and jitter statistics block.
// ---------------------------------------------------------------------------
`default_nettype none
package ufljs_pkg;

  localparam int unsigned SEQ_LO_W     = 8;
  localparam logic [7:0]  SEQ_HI_MAX   = 8'hFF;
  localparam logic [7:0]  HI_WRAP_LOW  = 8'd1;
  localparam logic [7:0]  HI_WRAP_HIGH = SEQ_HI_MAX - 8'd1;
  localparam logic [10:0] MS_PER_SEC   = 11'd1000;
  localparam logic [9:0]  TIME_MAX_MS  = 10'd999;

  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  localparam logic [2:0] CFG_ADDR_VIDEO_EN = 3'd0;

  // controller -> datapath
  typedef struct packed {
    logic load;         // latch an accepted input beat
    logic pkt_a;        // gap and square
    logic pkt_b;        // commit sums, bitmap bit and window
    logic walk_init;
    logic walk_issue;
    logic emit;
    logic last;
    logic sid;
    logic clr_step;
    logic clr_scalars;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic win_valid;
    logic walk_last;
    logic clr_last;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== design/udp_flow_loss_jitter_stats.sv =====
// Packet beat: after acceptance the capture, gap/square and commit steps run before ready is raised again.
// Report beat: per reported sub-stream the window is walked, one bitmap bit read per cycle (up to
// 65536; no walk for an empty window), then the result waits until it is taken.
// After a report and after reset a clearing pass zeroes the bitmap memory of 2^(9+BW) bits
// with BW = max(1, clog2(BITMAP_BLOCKS)), 4096 at the default; no beat is taken meanwhile.
// Reset is synchronous, active low; config writes are accepted at all times.
// ---------------------------------------------------------------------------
// udp_flow_loss_jitter_stats
// Loss and jitter statistics for the voice and video sub-streams of a flow.
// ---------------------------------------------------------------------------
`default_nettype none
module udp_flow_loss_jitter_stats
  import ufljs_pkg::*;
#(
  parameter int unsigned BITMAP_BLOCKS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [47:0]  in_tdata,   // sequence_number, time_ms, packet_length
  input  wire logic [1:0]   in_tuser,   // action, is_video
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // received_count, byte_total, interval_total, interval_max,
  // interval_square_total, lost_count, longest_loss_run
  output logic [159:0]      out_tdata,
  output logic [0:0]        out_tuser,  // stream_id
  output logic              out_tlast,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic  video_en_r;
  cmd_t  cmd;
  stat_t stat;
  logic  in_fire;
  logic [16:0] o_rx;
  logic [31:0] o_bytes, o_gsum, o_gsq;
  logic [9:0]  o_gmax;
  logic [15:0] o_lost, o_run;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_VIDEO_EN) ? {31'd0, video_en_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_en_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_ADDR_VIDEO_EN) begin
      video_en_r <= cfg_pwdata[0];
    end
  end

  assign in_fire = in_tvalid & in_tready;

  ufljs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .video_en  (video_en_r),
    .in_fire   (in_fire),
    .in_action (in_tuser[0]),
    .stat      (stat),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  ufljs_dp #(.BITMAP_BLOCKS(BITMAP_BLOCKS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_is_video (in_tuser[1]),
    .in_seq      (in_tdata[15:0]),
    .in_time     (in_tdata[25:16]),
    .in_len      (in_tdata[41:26]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tlast   (out_tlast),
    .out_sid     (out_tuser[0]),
    .out_rx      (o_rx),
    .out_bytes   (o_bytes),
    .out_gsum    (o_gsum),
    .out_gmax    (o_gmax),
    .out_gsq     (o_gsq),
    .out_lost    (o_lost),
    .out_run     (o_run)
  );

  assign out_tdata = {5'd0, o_run, o_lost, o_gsq, o_gmax, o_gsum, o_bytes, o_rx};

endmodule
`default_nettype wire

// ===== design/ufljs_ctrl.sv =====
// ---------------------------------------------------------------------------
// ufljs_ctrl
// Sequencer: packet update steps, window walk per sub-stream, result hand-off
// and the bitmap clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
module ufljs_ctrl
  import ufljs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  video_en,
  input  wire logic  in_fire,
  input  wire logic  in_action,
  input  wire stat_t stat,
  output logic       in_ready,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PKT_A  = 3'd1;
  localparam logic [2:0] S_PKT_B  = 3'd2;
  localparam logic [2:0] S_W_INIT = 3'd3;
  localparam logic [2:0] S_W_RUN  = 3'd4;
  localparam logic [2:0] S_W_DRN  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;
  localparam logic [2:0] S_CLEAR  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       sid_r, sid_nxt;
  logic       last_stream;

  assign in_ready    = (state_r == S_IDLE);
  assign last_stream = sid_r | ~video_en;

  always_comb begin
    state_nxt = state_r;
    sid_nxt   = sid_r;
    cmd       = '0;
    cmd.sid   = sid_r;
    cmd.last  = last_stream;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          if (in_action == ACT_REPORT) begin
            sid_nxt   = 1'b0;
            state_nxt = S_W_INIT;
          end else begin
            state_nxt = S_PKT_A;
          end
        end
      end
      S_PKT_A: begin
        cmd.pkt_a = 1'b1;
        state_nxt = S_PKT_B;
      end
      S_PKT_B: begin
        cmd.pkt_b = 1'b1;
        state_nxt = S_IDLE;
      end
      S_W_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = stat.win_valid ? S_W_RUN : S_EMIT;
      end
      S_W_RUN: begin
        cmd.walk_issue = 1'b1;
        if (stat.walk_last) state_nxt = S_W_DRN;
      end
      S_W_DRN: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          if (last_stream) begin
            cmd.clr_scalars = 1'b1;
            state_nxt       = S_CLEAR;
          end else begin
            sid_nxt   = 1'b1;
            state_nxt = S_W_INIT;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sid_r   <= sid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ufljs_dp.sv =====
// ---------------------------------------------------------------------------
// ufljs_dp
// Datapath: per sub-stream totals and window, the sequence bitmap memory,
// the walk counters and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module ufljs_dp
  import ufljs_pkg::*;
#(
  parameter int unsigned BITMAP_BLOCKS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic        in_is_video,
  input  wire logic [15:0] in_seq,
  input  wire logic [9:0]  in_time,
  input  wire logic [15:0] in_len,
  input  wire logic        out_tready,
  output logic             out_tvalid,
  output logic             out_tlast,
  output logic             out_sid,
  output logic [16:0]      out_rx,
  output logic [31:0]      out_bytes,
  output logic [31:0]      out_gsum,
  output logic [9:0]       out_gmax,
  output logic [31:0]      out_gsq,
  output logic [15:0]      out_lost,
  output logic [15:0]      out_run
);

  localparam int unsigned BW = (BITMAP_BLOCKS > 1) ? $clog2(BITMAP_BLOCKS) : 1;
  localparam int unsigned AW = 1 + BW + SEQ_LO_W;

  // block of a sequence number's upper byte
  logic [BW-1:0] blk_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_blk
    assign blk_tab[g] = BW'(g % BITMAP_BLOCKS);
  end

  logic        bm_mem [2**AW];
  logic        rd_bit_r;
  logic [AW-1:0] clr_addr_r;

  logic        sid_r;
  logic [15:0] seq_r, len_r;
  logic [9:0]  time_r, tsat_r, gap_r;
  logic [19:0] sq_r;

  logic [15:0] wstart_r [2];
  logic [15:0] wend_r   [2];
  logic [1:0]  wvalid_r, tvalid_r;
  logic [9:0]  ltime_r  [2];
  logic [31:0] bsum_r   [2];
  logic [31:0] gsum_r   [2];
  logic [9:0]  gpeak_r  [2];
  logic [31:0] gsq_r    [2];

  logic [16:0] widx_r, wend17_r, idx_d_r, prev_r;
  logic        rd_pend_r, have_r;
  logic [16:0] rx_r, lost_r, run_r;

  logic        cs;
  logic [9:0]  tsat, gap_c;
  logic [15:0] st_nxt, en_nxt;
  logic [7:0]  hi, st_hi, en_hi;
  logic [8:0]  st_idx, cur_idx;
  logic [16:0] gap_w;

  assign cs = (cmd.pkt_a | cmd.pkt_b) ? sid_r : cmd.sid;

  assign tsat  = (time_r > TIME_MAX_MS) ? TIME_MAX_MS : time_r;
  assign gap_c = (tsat >= ltime_r[cs]) ? tsat - ltime_r[cs]
               : 10'(11'(tsat) + MS_PER_SEC - 11'(ltime_r[cs]));

  assign hi      = seq_r[15:8];
  assign st_hi   = wstart_r[cs][15:8];
  assign en_hi   = wend_r[cs][15:8];
  assign st_idx  = 9'(blk_tab[st_hi]) + 9'(wstart_r[cs][7:0]);
  assign cur_idx = 9'(blk_tab[hi]) + 9'(seq_r[7:0]);

  always_comb begin
    st_nxt = wstart_r[cs];
    en_nxt = wend_r[cs];
    if (!wvalid_r[cs]) begin
      st_nxt = seq_r;
      en_nxt = seq_r;
    end else begin
      if (hi >= HI_WRAP_HIGH && st_hi <= HI_WRAP_LOW) begin
        st_nxt = seq_r;
      end else if (hi <= HI_WRAP_LOW && st_hi >= HI_WRAP_HIGH) begin
        if (st_idx < cur_idx) st_nxt = seq_r + 16'd1;
      end else if (seq_r < wstart_r[cs]) begin
        st_nxt = seq_r;
      end
      if (en_hi >= HI_WRAP_HIGH && hi <= HI_WRAP_LOW) begin
        en_nxt = seq_r;
      end else if (!(en_hi <= HI_WRAP_LOW && hi >= HI_WRAP_HIGH) && seq_r > wend_r[cs]) begin
        en_nxt = seq_r;
      end
    end
  end

  assign gap_w = idx_d_r - prev_r - 17'd1;

  assign stat.win_valid = wvalid_r[cmd.sid];
  assign stat.walk_last = (widx_r == wend17_r);
  assign stat.clr_last  = &clr_addr_r;
  assign stat.out_busy  = out_tvalid & ~out_tready;

  // bitmap memory: bit set on packet commit, zeroed by the clearing pass
  always_ff @(posedge clk) begin
    if (cmd.pkt_b) bm_mem[{sid_r, blk_tab[seq_r[15:8]], seq_r[7:0]}] <= 1'b1;
    else if (cmd.clr_step) bm_mem[clr_addr_r] <= 1'b0;
    if (cmd.walk_issue)
      rd_bit_r <= bm_mem[{cmd.sid, blk_tab[widx_r[15:8]], widx_r[7:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sid_r  <= in_is_video;
      seq_r  <= in_seq;
      time_r <= in_time;
      len_r  <= in_len;
    end
    if (cmd.pkt_a) begin
      tsat_r <= tsat;
      gap_r  <= gap_c;
      sq_r   <= 20'(gap_c * gap_c);
    end
    if (cmd.walk_init) begin
      widx_r   <= {1'b0, wstart_r[cmd.sid]};
      wend17_r <= {(wstart_r[cmd.sid] > wend_r[cmd.sid]), wend_r[cmd.sid]};
    end else if (cmd.walk_issue) begin
      widx_r <= widx_r + 17'd1;
    end
    idx_d_r <= widx_r;
    if (cmd.emit) begin
      out_tlast <= cmd.last;
      out_sid   <= cmd.sid;
      out_rx    <= rx_r;
      out_bytes <= bsum_r[cmd.sid];
      out_gsum  <= gsum_r[cmd.sid];
      out_gmax  <= gpeak_r[cmd.sid];
      out_gsq   <= gsq_r[cmd.sid];
      out_lost  <= lost_r[15:0];
      out_run   <= run_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_scalars) begin
      wvalid_r <= '0;
      tvalid_r <= '0;
      for (int i = 0; i < 2; i++) begin
        wstart_r[i] <= '0;
        wend_r[i]   <= '0;
        ltime_r[i]  <= '0;
        bsum_r[i]   <= '0;
        gsum_r[i]   <= '0;
        gpeak_r[i]  <= '0;
        gsq_r[i]    <= '0;
      end
    end else if (cmd.pkt_b) begin
      bsum_r[sid_r] <= bsum_r[sid_r] + 32'(len_r);
      if (tvalid_r[sid_r]) begin
        gsum_r[sid_r] <= gsum_r[sid_r] + 32'(gap_r);
        gsq_r[sid_r]  <= gsq_r[sid_r] + 32'(sq_r);
        if (gap_r > gpeak_r[sid_r]) gpeak_r[sid_r] <= gap_r;
      end
      ltime_r[sid_r]  <= tsat_r;
      tvalid_r[sid_r] <= 1'b1;
      wstart_r[sid_r] <= st_nxt;
      wend_r[sid_r]   <= en_nxt;
      wvalid_r[sid_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      rd_pend_r  <= 1'b0;
      have_r     <= 1'b0;
      out_tvalid <= 1'b0;
      rx_r       <= '0;
      lost_r     <= '0;
      run_r      <= '0;
      prev_r     <= '0;
    end else begin
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + AW'(1);
      rd_pend_r <= cmd.walk_issue;
      if (cmd.walk_init) begin
        have_r <= 1'b0;
        rx_r   <= '0;
        lost_r <= '0;
        run_r  <= '0;
      end else if (rd_pend_r && rd_bit_r) begin
        rx_r <= rx_r + 17'd1;
        if (have_r) begin
          lost_r <= lost_r + gap_w;
          if (gap_w > run_r) run_r <= gap_w;
        end
        have_r <= 1'b1;
        prev_r <= idx_d_r;
      end
      if (cmd.emit) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_pend_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !cmd.pkt_b) else $error("bitmap read pending during packet commit");
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_issue |-> widx_r <= wend17_r) else $error("walk past window end");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_tvalid && !out_tready)) else $error("result overwritten");
`endif

endmodule
`default_nettype wire

// ===== tb/udp_flow_loss_jitter_stats_tb.sv =====
// ---------------------------------------------------------------------------
// udp_flow_loss_jitter_stats_tb
// Drives packet and report beats with random gaps and back-pressure, tracks
// the per sub-stream sums, gap statistics, bitmap and window in a local
// predictor, and checks every result beat field by field against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module udp_flow_loss_jitter_stats_tb;
  import ufljs_pkg::*;

  localparam int unsigned BLOCKS = 8;
  localparam logic [2:0] CFG_ADDR_SPARE = 3'd4;  // no register here

  typedef struct packed {
    logic        sid;
    logic [16:0] rx;
    logic [31:0] bytes;
    logic [31:0] gaps;
    logic [9:0]  peak;
    logic [31:0] sq;
    logic [15:0] lost;
    logic [15:0] run;
    logic        fin;
  } stats_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;   // sequence_number, time_ms, packet_length
  logic [1:0]   in_tuser = '0;   // action, is_video
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;       // received_count .. longest_loss_run
  logic [0:0]   out_tuser;       // stream_id
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  udp_flow_loss_jitter_stats u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  bit [255:0]  seen_map [2][BLOCKS];
  bit [15:0]   win_start [2];
  bit [15:0]   win_end [2];
  bit          win_ok [2];
  bit [9:0]    prev_ms [2];
  bit          ms_ok [2];
  bit [31:0]   byte_acc [2];
  bit [31:0]   gap_acc [2];
  bit [9:0]    gap_top [2];
  bit [31:0]   sq_acc [2];
  bit          video_on;

  stats_t      pending_stats [$];
  int          fail_count = 0;
  int          beats_sent = 0;
  int          wide_bursts = 0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;
  int          out_hold = 0;

  function automatic void clear_flow();
    for (int s = 0; s < 2; s++) begin
      for (int b = 0; b < BLOCKS; b++) seen_map[s][b] = '0;
      win_start[s] = '0; win_end[s] = '0; win_ok[s] = 1'b0;
      prev_ms[s] = '0; ms_ok[s] = 1'b0;
      byte_acc[s] = '0; gap_acc[s] = '0; gap_top[s] = '0; sq_acc[s] = '0;
    end
  endfunction

  function automatic bit is_seen(bit s, bit [15:0] n);
    return seen_map[s][n[15:8] % BLOCKS][n[7:0]];
  endfunction

  function automatic void move_window(bit s, bit [15:0] seq);
    bit [7:0] cur_hi, st_hi, en_hi;
    int unsigned st_idx, cur_idx;
    cur_hi = seq[15:8];
    st_hi = win_start[s][15:8];
    en_hi = win_end[s][15:8];
    st_idx = st_hi % BLOCKS + win_start[s][7:0];
    cur_idx = cur_hi % BLOCKS + seq[7:0];
    if (!win_ok[s]) begin
      win_start[s] = seq; win_end[s] = seq; win_ok[s] = 1'b1;
      return;
    end
    if (cur_hi >= HI_WRAP_HIGH && st_hi <= HI_WRAP_LOW) begin
      win_start[s] = seq;
    end else if (cur_hi <= HI_WRAP_LOW && st_hi >= HI_WRAP_HIGH) begin
      if (st_idx < cur_idx) win_start[s] = seq + 16'd1;
    end else if (seq < win_start[s]) begin
      win_start[s] = seq;
    end
    if (en_hi >= HI_WRAP_HIGH && cur_hi <= HI_WRAP_LOW) begin
      win_end[s] = seq;
    end else if (!(en_hi <= HI_WRAP_LOW && cur_hi >= HI_WRAP_HIGH)) begin
      if (seq > win_end[s]) win_end[s] = seq;
    end
  endfunction

  function automatic void take_packet(bit s, bit [15:0] seq, bit [9:0] ms, bit [15:0] len);
    bit [31:0] gap;
    if (ms > TIME_MAX_MS) ms = TIME_MAX_MS;
    byte_acc[s] += 32'(len);
    if (ms_ok[s]) begin
      gap = (ms >= prev_ms[s]) ? ms - prev_ms[s] : ms + 32'd1000 - prev_ms[s];
      gap_acc[s] += gap;
      if (gap > gap_top[s]) gap_top[s] = gap[9:0];
      sq_acc[s] += gap * gap;
    end
    prev_ms[s] = ms;
    ms_ok[s] = 1'b1;
    seen_map[s][seq[15:8] % BLOCKS][seq[7:0]] = 1'b1;
    move_window(s, seq);
  endfunction

  function automatic stats_t walk_window(bit s, bit fin);
    stats_t r;
    int unsigned idx, stop, prev, rx, lost, run, gap;
    bit have;
    rx = 0; lost = 0; run = 0; prev = 0; have = 1'b0;
    if (win_ok[s]) begin
      idx = 32'(win_start[s]);
      stop = 32'(win_end[s]);
      if (idx > stop) stop += 65536;
      for (; idx <= stop; idx++) begin
        if (is_seen(s, idx[15:0])) begin
          rx++;
          if (have) begin
            gap = idx - prev - 1;
            lost += gap;
            if (gap > run) run = gap;
          end
          have = 1'b1;
          prev = idx;
        end
      end
    end
    r.sid = s; r.rx = rx[16:0]; r.bytes = byte_acc[s]; r.gaps = gap_acc[s];
    r.peak = gap_top[s]; r.sq = sq_acc[s]; r.lost = lost[15:0]; r.run = run[15:0];
    r.fin = fin;
    return r;
  endfunction

  function automatic void take_beat(bit act, bit s, bit [15:0] seq, bit [9:0] ms,
                                    bit [15:0] len);
    if (act == ACT_PACKET) begin
      take_packet(s, seq, ms, len);
      return;
    end
    if (video_on) begin
      pending_stats.push_back(walk_window(1'b0, 1'b0));
      pending_stats.push_back(walk_window(1'b1, 1'b1));
    end else begin
      pending_stats.push_back(walk_window(1'b0, 1'b1));
    end
    clear_flow();
  endfunction

  // caller sits just after a falling edge; tvalid is left high, the next
  // beat or an idle wait drops it
  task automatic send_beat(bit act, bit s, bit [15:0] seq, bit [9:0] ms, bit [15:0] len);
    int idle;
    idle = quiet_in ? 0 : $urandom_range(0, 14);
    if (idle > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {s, act};
    in_tdata <= {6'd0, len, ms, seq};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    take_beat(act, s, seq, ms, len);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(bit s, bit [15:0] seq, bit [9:0] ms, bit [15:0] len);
    send_beat(ACT_PACKET, s, seq, ms, len);
  endtask

  task automatic send_report();
    send_beat(ACT_REPORT, 1'($urandom_range(0, 1)), 16'($urandom), 10'($urandom),
              16'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
  endtask

  // drain, then let the clearing pass after a report finish before touching config
  task automatic write_cfg(logic [2:0] addr, logic [31:0] data);
    wait_drained();
    repeat (4200) @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= data;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == CFG_ADDR_VIDEO_EN) video_on = data[0];
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      out_hold = quiet_out ? 0 : $urandom_range(0, 14);
      if (pending_stats.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, out_tdata);
        fail_count++;
      end else begin
        want = pending_stats.pop_front();
        check_field("stream_id", want.sid, out_tuser[0]);
        check_field("received_count", want.rx, out_tdata[16:0]);
        check_field("byte_total", want.bytes, out_tdata[48:17]);
        check_field("interval_total", want.gaps, out_tdata[80:49]);
        check_field("interval_max", want.peak, out_tdata[90:81]);
        check_field("interval_square_total", want.sq, out_tdata[122:91]);
        check_field("lost_count", want.lost, out_tdata[138:123]);
        check_field("longest_loss_run", want.run, out_tdata[154:139]);
        check_field("last_of_report", want.fin, out_tlast);
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_empty_reports();
    send_report();
    write_cfg(CFG_ADDR_VIDEO_EN, 32'd1);
    send_report();
  endtask

  task automatic test_field_extremes();
    send_packet(1'b0, 16'd0, 10'd0, 16'd0);
    send_packet(1'b0, 16'hFFFF, 10'h3FF, 16'hFFFF);   // time saturates
    send_packet(1'b0, 16'd10, 10'd999, 16'h8000);
    send_packet(1'b1, 16'h5555, 10'd500, 16'h5555);
    send_packet(1'b1, 16'hAAAA, 10'd1, 16'hAAAA);      // gap wraps the second
    send_packet(1'b1, 16'h5555, 10'd1000, 16'd7);      // duplicate number
    send_report();
  endtask

  task automatic test_wrap_windows();
    send_packet(1'b0, 16'hFF10, 10'd0, 16'd100);
    send_packet(1'b0, 16'h0005, 10'd20, 16'd100);
    send_packet(1'b0, 16'hFF00, 10'd40, 16'd100);
    send_packet(1'b0, 16'h0120, 10'd60, 16'd100);
    send_packet(1'b1, 16'h0003, 10'd0, 16'd1);
    send_packet(1'b1, 16'hFE80, 10'd3, 16'd1);
    send_packet(1'b1, 16'h0100, 10'd9, 16'd1);
    send_report();
    // numbers sharing a bitmap block
    send_packet(1'b0, 16'h0205, 10'd0, 16'd1);
    send_packet(1'b0, 16'h0A07, 10'd5, 16'd1);
    send_packet(1'b0, 16'h0209, 10'd6, 16'd1);
    send_report();
  endtask

  task automatic test_video_disabled();
    write_cfg(CFG_ADDR_SPARE, 32'd0);   // nothing lives there, video stays on
    write_cfg(CFG_ADDR_VIDEO_EN, 32'd0);
    send_packet(1'b1, 16'd40, 10'd10, 16'd9);
    send_packet(1'b0, 16'd41, 10'd12, 16'd9);
    send_report();
    write_cfg(CFG_ADDR_VIDEO_EN, 32'hFFFF_FFFF);
    send_report();   // video state must have been cleared
  endtask

  task automatic run_burst();
    int n, kind;
    bit [15:0] base, seq;
    bit one_side;
    n = $urandom_range(3, 40);
    kind = $urandom_range(0, 99);
    if (kind >= 92 && wide_bursts >= 3) kind = 0;
    if (kind >= 92) wide_bursts++;
    base = 16'($urandom);
    one_side = ($urandom_range(0, 3) == 0);
    quiet_in = ($urandom_range(0, 4) == 0);
    quiet_out = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if (kind < 80) seq = base + 16'($urandom_range(0, 255));
      else if (kind < 92) seq = $urandom_range(0, 1) ? 16'hFE00 + 16'($urandom_range(0, 511))
                                                      : 16'($urandom_range(0, 511));
      else seq = 16'($urandom);
      send_packet(one_side ? 1'b0 : 1'($urandom_range(0, 1)), seq, 10'($urandom),
                  16'($urandom));
    end
    send_report();
  endtask

  task automatic test_random_traffic();
    while (beats_sent < 1350) begin
      if ($urandom_range(0, 11) == 0) write_cfg(CFG_ADDR_VIDEO_EN, $urandom);
      else if ($urandom_range(0, 15) == 0) wait_drained();
      run_burst();
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    int guard;
    clear_flow();
    video_on = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_reports();
    test_field_extremes();
    test_wrap_windows();
    test_video_disabled();
    test_random_traffic();
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_stats.size() != 0 && guard < 400000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (pending_stats.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_stats.size());
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2s;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
